// File: src/ssve_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssve_pkg: shared types and constants of the slice sample to voxel emitter
// Field widths, register indexes, register reset values and the config
// bundle that the datapath parts share.
// ----------------------------------------------------------------------------
package ssve_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int DIM_W     = 15;
  localparam int TOTAL_W   = 9;
  localparam int BYTE_W    = 8;
  localparam int MASK_W    = 32;
  localparam int LAYER_W   = 16;
  localparam int POS_W     = 16;
  localparam int RGBA_W    = 32;
  localparam int CFG_IDX_W = 4;
  localparam int PROD_W    = 25;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_X         = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_Y         = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_TOTAL    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_REPEAT   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LUM_THRESHOLD  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RESCALE_FLOOR  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_MASKS      = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_FROM_LUM = 4'd7;

  // Rescale constants: stretch factor base and the product at which the
  // quotient by 255 reaches 256 (256 * 255).
  localparam logic [BYTE_W:0]   RESCALE_BASE = 9'd255;
  localparam logic [PROD_W-1:0] SAT_PRODUCT  = 25'd65280;
  localparam logic [SAMPLE_W-1:0] LUM_SAT    = 16'h00FF;
  localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic [DIM_W-1:0]   span_x;
    logic [DIM_W-1:0]   span_y;
    logic [TOTAL_W-1:0] slice_total;
    logic [BYTE_W-1:0]  depth_repeat;
    logic [BYTE_W-1:0]  lum_threshold;
    logic [BYTE_W-1:0]  rescale_floor;
    logic [MASK_W-1:0]  bit_masks;
    logic               alpha_from_lum;
  } ssve_cfg_t;

  localparam ssve_cfg_t CFG_RESET = '{
    span_x:         15'd256,
    span_y:         15'd256,
    slice_total:    9'd1,
    depth_repeat:   8'd1,
    lum_threshold:  8'd0,
    rescale_floor:  8'd0,
    bit_masks:      32'h0000_00FF,
    alpha_from_lum: 1'b0
  };

endpackage

// File: src/slice_sample_to_voxel_emitter_top.sv
`timescale 1ns / 1ps
// Pipeline: an accepted request passes two register stages, sample and
//   result, before its voxel shows on the outputs.
// Throughput: one sample per cycle when not stalled, set by the single-pass
//   datapath and the position counters; a stalled result blocks intake once
//   the sample stage behind it is also full.
// Reset: rst_n is synchronous, active low; clears both stage valids, the
//   scan counters, and returns every config register to its default.
// ----------------------------------------------------------------------------
// slice_sample_to_voxel_emitter_top: volume sample to voxel emitter
// Turns a stream of 16-bit volume samples in scan order into gray RGBA
// voxels with centered coordinates, dropping samples at or below the threshold.
// ----------------------------------------------------------------------------
module slice_sample_to_voxel_emitter_top #(
  parameter int COORD_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration write port
  input  logic                                 cfg_we,
  input  logic [ssve_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ssve_pkg::MASK_W-1:0]          cfg_wdata,
  // sample requests
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [ssve_pkg::SAMPLE_W-1:0]        in_sample,
  // voxel results
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [ssve_pkg::RGBA_W-1:0]          out_rgba,
  output logic signed [ssve_pkg::POS_W-1:0]    out_pos_x,
  output logic signed [ssve_pkg::POS_W-1:0]    out_pos_y,
  output logic signed [ssve_pkg::POS_W-1:0]    out_pos_z
);
  import ssve_pkg::*;

  ssve_cfg_t cfg_r;

  // scan position of the next request
  logic [DIM_W-1:0]   scan_x, scan_y;
  logic [LAYER_W-1:0] scan_layer;

  // sample stage
  logic                s1_valid_r;
  logic [SAMPLE_W-1:0] s1_sample_r;
  logic [DIM_W-1:0]    s1_x_r, s1_y_r;
  logic [LAYER_W-1:0]  s1_layer_r;

  // result stage
  logic                out_valid_r;
  logic [RGBA_W-1:0]   out_rgba_r;
  logic [POS_W-1:0]    out_pos_x_r, out_pos_y_r, out_pos_z_r;

  logic                in_acc, out_load, hit;
  logic [RGBA_W-1:0]   rgba;
  logic [POS_W-1:0]    diff_x, diff_y, diff_z, z_offset;
  logic [POS_W-1:0]    pos_x, pos_y, pos_z;

  // ---------------------------------------------------------------------------
  // Configuration registers: unknown indexes are dropped.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SPAN_X:         cfg_r.span_x         <= cfg_wdata[DIM_W-1:0];
        CFG_SPAN_Y:         cfg_r.span_y         <= cfg_wdata[DIM_W-1:0];
        CFG_SLICE_TOTAL:    cfg_r.slice_total    <= cfg_wdata[TOTAL_W-1:0];
        CFG_DEPTH_REPEAT:   cfg_r.depth_repeat   <= cfg_wdata[BYTE_W-1:0];
        CFG_LUM_THRESHOLD:  cfg_r.lum_threshold  <= cfg_wdata[BYTE_W-1:0];
        CFG_RESCALE_FLOOR:  cfg_r.rescale_floor  <= cfg_wdata[BYTE_W-1:0];
        CFG_BIT_MASKS:      cfg_r.bit_masks      <= cfg_wdata;
        CFG_ALPHA_FROM_LUM: cfg_r.alpha_from_lum <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: the result register loads whenever it is empty or being
  // taken; the sample stage advances whenever it can hand off or is empty.
  // ---------------------------------------------------------------------------
  assign out_load = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_load;
  assign in_acc   = in_valid && !in_stall;

  // Position counters advance on every accepted request, voxel or not.
  ssve_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (in_acc),
    .cfg     (cfg_r),
    .x_r     (scan_x),
    .y_r     (scan_y),
    .layer_r (scan_layer)
  );

  // Hold the sample with the position it was taken at.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample_r <= in_sample;
      s1_x_r      <= scan_x;
      s1_y_r      <= scan_y;
      s1_layer_r  <= scan_layer;
    end
  end

  ssve_lum u_lum (
    .sample (s1_sample_r),
    .cfg    (cfg_r),
    .hit    (hit),
    .rgba   (rgba)
  );

  // ---------------------------------------------------------------------------
  // Centered coordinates: wrap to COORD_BITS, then sign-extend to the port.
  // ---------------------------------------------------------------------------
  always_comb begin
    z_offset = POS_W'(cfg_r.slice_total[TOTAL_W-1:1]) * POS_W'(cfg_r.depth_repeat);
    diff_x   = POS_W'(s1_x_r) - POS_W'(cfg_r.span_x[DIM_W-1:1]);
    diff_y   = POS_W'(s1_y_r) - POS_W'(cfg_r.span_y[DIM_W-1:1]);
    diff_z   = POS_W'(s1_layer_r) - z_offset;
    pos_x    = POS_W'($signed(diff_x[COORD_BITS-1:0]));
    pos_y    = POS_W'($signed(diff_y[COORD_BITS-1:0]));
    pos_z    = POS_W'($signed(diff_z[COORD_BITS-1:0]));
  end

  // Result register: load a voxel only when the luminance passes; drop
  // the rest as the sample stage drains.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid_r && hit) begin
      out_rgba_r  <= rgba;
      out_pos_x_r <= pos_x;
      out_pos_y_r <= pos_y;
      out_pos_z_r <= pos_z;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rgba  = out_rgba_r;
  assign out_pos_x = out_pos_x_r;
  assign out_pos_y = out_pos_y_r;
  assign out_pos_z = out_pos_z_r;

endmodule

// File: src/ssve_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssve_scan: scan position counters
// Tracks y (innermost), x and layer index; advances once per request.
// ----------------------------------------------------------------------------
module ssve_scan (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             advance,
  input  ssve_pkg::ssve_cfg_t              cfg,
  output logic [ssve_pkg::DIM_W-1:0]       x_r,
  output logic [ssve_pkg::DIM_W-1:0]       y_r,
  output logic [ssve_pkg::LAYER_W-1:0]     layer_r
);
  import ssve_pkg::*;

  logic [DIM_W-1:0]   x_nxt, y_nxt, x_inc, y_inc;
  logic [LAYER_W-1:0] layer_nxt, layer_inc;
  logic [LAYER_W:0]   layer_limit;

  assign layer_limit = (LAYER_W+1)'(cfg.slice_total) * (LAYER_W+1)'(cfg.depth_repeat);

  always_comb begin
    y_inc     = y_r + 1'b1;
    x_inc     = x_r + 1'b1;
    layer_inc = layer_r + 1'b1;
    x_nxt     = x_r;
    y_nxt     = y_inc;
    layer_nxt = layer_r;
    // A limit that is zero or already passed returns the counter to 0 at once.
    if (y_inc >= cfg.span_y) begin
      y_nxt = '0;
      x_nxt = x_inc;
      if (x_inc >= cfg.span_x) begin
        x_nxt     = '0;
        layer_nxt = layer_inc;
        if ({1'b0, layer_inc} >= layer_limit) begin
          layer_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r     <= '0;
      y_r     <= '0;
      layer_r <= '0;
    end else if (advance) begin
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      layer_r <= layer_nxt;
    end
  end

endmodule

// File: src/ssve_lum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssve_lum: luminance, rescale and color
// Masks the sample, applies the optional floor/stretch, compares against
// the threshold and builds the gray RGBA word.
// ----------------------------------------------------------------------------
module ssve_lum (
  input  logic [ssve_pkg::SAMPLE_W-1:0]  sample,
  input  ssve_pkg::ssve_cfg_t            cfg,
  output logic                           hit,
  output logic [ssve_pkg::RGBA_W-1:0]    rgba
);
  import ssve_pkg::*;

  logic [SAMPLE_W-1:0] lum_raw, lum_sub, lum_fin;
  logic [BYTE_W:0]     factor;
  logic [PROD_W-1:0]   prod;
  logic [SAMPLE_W:0]   quot_sum;
  logic                sat;

  always_comb begin
    lum_raw = ((sample & cfg.bit_masks[15:0]) ^ cfg.bit_masks[31:16]) << 4;
    lum_sub = (lum_raw < SAMPLE_W'(cfg.rescale_floor)) ? '0
            : lum_raw - SAMPLE_W'(cfg.rescale_floor);
    factor  = RESCALE_BASE + (BYTE_W+1)'(cfg.rescale_floor);
    prod    = PROD_W'(lum_sub) * PROD_W'(factor);
    sat     = (prod >= SAT_PRODUCT);
    // Exact floor(p / 255) for p below 65535: (p + (p >> 8) + 1) >> 8.
    quot_sum = (SAMPLE_W+1)'(prod[15:0]) + (SAMPLE_W+1)'(prod[15:8]) + 1'b1;
    if (cfg.rescale_floor == '0) begin
      lum_fin = lum_raw;
    end else if (sat) begin
      lum_fin = LUM_SAT;
    end else begin
      lum_fin = SAMPLE_W'(quot_sum[15:8]);
    end

    hit  = lum_fin > SAMPLE_W'(cfg.lum_threshold);
    rgba = RGBA_W'(ALPHA_OPAQUE) | (RGBA_W'(lum_fin) << 8)
         | (RGBA_W'(lum_fin) << 16) | (RGBA_W'(lum_fin) << 24);
    if (cfg.alpha_from_lum) begin
      rgba[7:0] = lum_fin[7:0];
    end
  end

endmodule

// File: dv/tb_slice_sample_to_voxel_emitter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_slice_sample_to_voxel_emitter_top: self-checking bench for the emitter
// Feeds 16-bit volume samples through the valid/stall request port. Each
// accepted request runs through a cycle-free voxel predictor that keeps its
// own copy of the settings and scan position. Every voxel that leaves the
// block is checked field by field against the oldest predicted voxel. A short
// directed sweep covers the luminance and counter corner cases. Random phases
// follow under several settings and idle patterns, including one long output
// hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_slice_sample_to_voxel_emitter_top;
  import ssve_pkg::*;

  localparam int COORD_BITS       = 16;
  localparam int ITEMS_PER_PHASE  = 178;
  localparam int PHASE_COUNT      = 8;
  localparam int SETTLE_CYCLES    = 6;    // two-stage pipe plus margin
  localparam int HOLD_OFF_CYCLES  = 300;
  localparam int QUIET_LIMIT      = 20000;
  // An index that maps to no register; the write must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 4'd13;

  typedef struct packed {
    logic [RGBA_W-1:0] rgba;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  pos_z;
  } voxel_t;

  // What the sender knows about a request it is about to offer.
  typedef struct {
    bit     exact;      // use the typed voxel below instead of the predictor
    bit     has_voxel;
    voxel_t vox;
  } request_note_t;

  typedef enum {ROW_PREDICT, ROW_EXACT, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [MASK_W-1:0]     value;   // sample in the low bits for request rows
    bit                    has_voxel;
    voxel_t                vox;
  } sweep_row_t;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // DUT ports
  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [MASK_W-1:0]      cfg_wdata;
  logic                   in_valid;
  logic                   in_stall;
  logic [SAMPLE_W-1:0]    in_sample;
  logic                   out_valid;
  logic                   out_stall;
  logic [RGBA_W-1:0]      out_rgba;
  logic signed [POS_W-1:0] out_pos_x;
  logic signed [POS_W-1:0] out_pos_y;
  logic signed [POS_W-1:0] out_pos_z;

  // Predictor copy of the settings and of the scan position
  int unsigned set_width, set_height, set_total, set_repeat;
  int unsigned set_threshold, set_floor, set_alpha;
  bit [31:0]   set_masks;
  int unsigned scan_x, scan_y, scan_layer;

  voxel_t        voxel_q[$];        // predicted voxels, oldest first
  request_note_t request_note_q[$]; // notes of offered requests, oldest first
  sweep_row_t    sweep_rows[$];

  int          fail_count;
  int          quiet_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_off_req;

  slice_sample_to_voxel_emitter_top #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rgba  (out_rgba),
    .out_pos_x (out_pos_x),
    .out_pos_y (out_pos_y),
    .out_pos_z (out_pos_z)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Wrap a 32-bit difference to COORD_BITS as a signed value, then
  // sign-extend it to the 16-bit position field.
  function automatic logic [POS_W-1:0] wrap_coord(input bit [31:0] v);
    logic [POS_W-1:0] w;
    w = v[POS_W-1:0];
    for (int i = COORD_BITS; i < POS_W; i++) w[i] = v[COORD_BITS-1];
    return w;
  endfunction

  // Work out the voxel of one sample at the current scan position.
  // Returns 1 when the luminance clears the threshold.
  function automatic bit predict_voxel(input logic [SAMPLE_W-1:0] s,
                                       output voxel_t vox);
    logic [15:0] lum16;
    int unsigned lum;
    int unsigned stretched;
    bit [31:0]   color;
    lum16 = ((s & set_masks[15:0]) ^ set_masks[31:16]) << 4;
    lum   = lum16;
    if (set_floor != 0) begin
      lum       = (lum < set_floor) ? 0 : lum - set_floor;
      stretched = (lum * (255 + set_floor)) / 255;
      lum       = (stretched > 255) ? 255 : stretched;
    end
    // Wide luminance simply ORs overlapping bytes and drops what spills out.
    color = 32'h0000_00FF | (lum << 8) | (lum << 16) | (lum << 24);
    if (set_alpha != 0) color &= 32'hFFFF_FF00 | lum;
    vox.rgba  = color;
    vox.pos_x = wrap_coord(scan_x - set_width / 2);
    vox.pos_y = wrap_coord(scan_y - set_height / 2);
    vox.pos_z = wrap_coord(scan_layer - (set_total / 2) * set_repeat);
    return lum > set_threshold;
  endfunction

  // Step the scan position by one sample: y innermost, then x, then layer.
  // A limit already passed after a settings change snaps the counter to 0.
  task automatic advance_scan();
    scan_y = (scan_y + 1) & 32'h7FFF;
    if (scan_y >= set_height) begin
      scan_y = 0;
      scan_x = (scan_x + 1) & 32'h7FFF;
      if (scan_x >= set_width) begin
        scan_x     = 0;
        scan_layer = (scan_layer + 1) & 32'hFFFF;
        if (scan_layer >= set_total * set_repeat) scan_layer = 0;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: follow register writes, predict on every accepted request and
  // check every accepted voxel. All values are the ones seen at the edge.
  // ---------------------------------------------------------------------------
  request_note_t mon_note;
  voxel_t        mon_vox;
  voxel_t        mon_want;
  bit            mon_hit;

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SPAN_X:         set_width     = cfg_wdata[DIM_W-1:0];
          CFG_SPAN_Y:         set_height    = cfg_wdata[DIM_W-1:0];
          CFG_SLICE_TOTAL:    set_total     = cfg_wdata[TOTAL_W-1:0];
          CFG_DEPTH_REPEAT:   set_repeat    = cfg_wdata[BYTE_W-1:0];
          CFG_LUM_THRESHOLD:  set_threshold = cfg_wdata[BYTE_W-1:0];
          CFG_RESCALE_FLOOR:  set_floor     = cfg_wdata[BYTE_W-1:0];
          CFG_BIT_MASKS:      set_masks     = cfg_wdata;
          CFG_ALPHA_FROM_LUM: set_alpha     = cfg_wdata[0];
          default: ;  // unmapped index: drop the write
        endcase
      end

      if (in_valid && !in_stall) begin
        mon_hit = predict_voxel(in_sample, mon_vox);
        advance_scan();
        if (request_note_q.size() == 0) begin
          $display("%0t: request accepted with no request offered", $time);
          fail_count++;
        end else begin
          mon_note = request_note_q.pop_front();
          if (mon_note.exact) begin
            mon_hit = mon_note.has_voxel;
            mon_vox = mon_note.vox;
          end
        end
        if (mon_hit) voxel_q.push_back(mon_vox);
      end

      if (out_valid && !out_stall) begin
        if (voxel_q.size() == 0) begin
          $display("%0t: unexpected voxel rgba %h x %0d y %0d z %0d", $time,
                   out_rgba, out_pos_x, out_pos_y, out_pos_z);
          fail_count++;
        end else begin
          mon_want = voxel_q.pop_front();
          if (out_rgba !== mon_want.rgba) begin
            $display("%0t: rgba expected %h got %h", $time, mon_want.rgba, out_rgba);
            fail_count++;
          end
          if (out_pos_x !== mon_want.pos_x) begin
            $display("%0t: pos_x expected %h got %h", $time, mon_want.pos_x, out_pos_x);
            fail_count++;
          end
          if (out_pos_y !== mon_want.pos_y) begin
            $display("%0t: pos_y expected %h got %h", $time, mon_want.pos_y, out_pos_y);
            fail_count++;
          end
          if (out_pos_z !== mon_want.pos_z) begin
            $display("%0t: pos_z expected %h got %h", $time, mon_want.pos_z, out_pos_z);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog: count edges where no handshake or write lands.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls at the phase's rate, or one long counted hold-off
  // while the sender keeps offering requests.
  // ---------------------------------------------------------------------------
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side helpers; each starts and ends just after a rising edge.
  // ---------------------------------------------------------------------------

  // Offer one sample request and hold it until the block takes it.
  task automatic send_request(input logic [SAMPLE_W-1:0] s, input bit exact,
                              input bit has_voxel, input voxel_t vox);
    request_note_t note;
    note.exact     = exact;
    note.has_voxel = has_voxel;
    note.vox       = vox;
    request_note_q.push_back(note);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid, wait for every predicted voxel, then let the pipe empty out
  // (a sample that makes no voxel may still be in flight).
  task automatic settle();
    in_valid <= 1'b0;
    while (voxel_q.size() != 0 || request_note_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [MASK_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic add_predict(input logic [SAMPLE_W-1:0] s);
    sweep_row_t r;
    r.kind      = ROW_PREDICT;
    r.idx       = '0;
    r.value     = s;
    r.has_voxel = 1'b0;
    r.vox       = '0;
    sweep_rows.push_back(r);
  endtask

  task automatic add_exact(input logic [SAMPLE_W-1:0] s, input bit has_voxel,
                           input voxel_t vox);
    sweep_row_t r;
    r.kind      = ROW_EXACT;
    r.idx       = '0;
    r.value     = s;
    r.has_voxel = has_voxel;
    r.vox       = vox;
    sweep_rows.push_back(r);
  endtask

  task automatic add_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [MASK_W-1:0] val);
    sweep_row_t r;
    r.kind      = ROW_WRITE;
    r.idx       = idx;
    r.value     = val;
    r.has_voxel = 1'b0;
    r.vox       = '0;
    sweep_rows.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  int unsigned ph_width, ph_height, ph_total, ph_repeat;
  int unsigned ph_threshold, ph_floor, ph_alpha;
  bit [31:0]   ph_masks;
  idle_mode_t  ph_mode;
  logic [SAMPLE_W-1:0] rnd_sample;

  initial begin
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= '0;
    cfg_wdata  <= '0;
    in_valid   <= 1'b0;
    in_sample  <= '0;
    fail_count     = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_req   = 1'b0;

    // Predictor starts from the reset settings and a zero scan position.
    set_width     = CFG_RESET.span_x;
    set_height    = CFG_RESET.span_y;
    set_total     = CFG_RESET.slice_total;
    set_repeat    = CFG_RESET.depth_repeat;
    set_threshold = CFG_RESET.lum_threshold;
    set_floor     = CFG_RESET.rescale_floor;
    set_masks     = CFG_RESET.bit_masks;
    set_alpha     = CFG_RESET.alpha_from_lum;
    scan_x        = 0;
    scan_y        = 0;
    scan_layer    = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed sweep. Reset settings first: AND mask 0xFF, no XOR, lum = low
    // byte << 4. A zero sample makes no voxel; the brightest byte spills its
    // top nibble into the alpha-less top byte.
    add_exact(16'h0000, 1'b0, '0);
    add_exact(16'h00FF, 1'b1, '{32'hFFFF_F0FF, 16'hFF80, 16'hFF81, 16'h0000});
    add_exact(16'h0001, 1'b1, '{32'h1010_10FF, 16'hFF80, 16'hFF82, 16'h0000});
    add_predict(16'hFFFF);
    add_predict(16'hAAAA);
    add_predict(16'h5555);
    // Top threshold: 0xF0 stays dark, 0x100 clears it.
    add_write(CFG_LUM_THRESHOLD, 32'd255);
    add_predict(16'h000F);
    add_predict(16'h0010);
    // Wide luminance: full AND mask; bit 12 shifts out, leaving zero.
    add_write(CFG_BIT_MASKS, 32'h0000_FFFF);
    add_predict(16'hFFFF);
    add_predict(16'h0FFF);
    add_exact(16'h1000, 1'b0, '0);
    // XOR only: every sample gives the same wide luminance.
    add_write(CFG_BIT_MASKS, 32'hFFFF_0000);
    add_predict(16'h0000);
    add_predict(16'hFFFF);
    // Both masks full: the sample is inverted.
    add_write(CFG_BIT_MASKS, 32'hFFFF_FFFF);
    add_predict(16'h0000);
    // No mask bits at all: luminance is always zero.
    add_write(CFG_BIT_MASKS, 32'h0000_0000);
    add_exact(16'hFFFF, 1'b0, '0);
    // Deepest rescale: below the floor, just above it, and saturated.
    add_write(CFG_BIT_MASKS, 32'h0000_00FF);
    add_write(CFG_LUM_THRESHOLD, 32'd0);
    add_write(CFG_RESCALE_FLOOR, 32'd255);
    add_predict(16'h000F);
    add_predict(16'h0010);
    add_predict(16'h001F);
    // Alpha from luminance, then the mildest rescale.
    add_write(CFG_ALPHA_FROM_LUM, 32'd1);
    add_predict(16'h0013);
    add_write(CFG_RESCALE_FLOOR, 32'd1);
    add_predict(16'h0001);
    add_predict(16'h0000);
    // Tiny volume: the counters already sit past the new limits, then the
    // layer counter wraps after total * repeat layers. The unmapped write
    // must leave everything as is.
    add_write(CFG_SPAN_X, 32'd1);
    add_write(CFG_SPAN_Y, 32'd1);
    add_write(CFG_SLICE_TOTAL, 32'd2);
    add_write(CFG_DEPTH_REPEAT, 32'd2);
    add_write(CFG_UNMAPPED, 32'hFFFF_FFFF);
    repeat (5) add_predict(16'h00F0);

    foreach (sweep_rows[i]) begin
      case (sweep_rows[i].kind)
        ROW_WRITE: begin
          settle();
          write_reg(sweep_rows[i].idx, sweep_rows[i].value);
        end
        ROW_EXACT: begin
          send_request(sweep_rows[i].value[SAMPLE_W-1:0], 1'b1,
                       sweep_rows[i].has_voxel, sweep_rows[i].vox);
        end
        default: begin
          send_request(sweep_rows[i].value[SAMPLE_W-1:0], 1'b0, 1'b0, '0);
        end
      endcase
    end
    settle();

    // Random phases: cycle through the idle patterns; first phase takes the
    // largest spans, second the smallest volume, the rest random, mostly small.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      ph_mode = idle_mode_t'(ph % 4);
      case (ph)
        0: begin
          ph_width = 32767; ph_height = 32767; ph_total = 256; ph_repeat = 255;
          ph_threshold = 0; ph_floor = 0; ph_masks = 32'hFFFF_FFFF; ph_alpha = 1;
        end
        1: begin
          ph_width = 1; ph_height = 1; ph_total = 1; ph_repeat = 1;
          ph_threshold = 254; ph_floor = 255; ph_masks = 32'h0000_FFFF;
          ph_alpha = 0;
        end
        default: begin
          ph_width  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32767)
                                                  : $urandom_range(1, 6);
          ph_height = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32767)
                                                  : $urandom_range(1, 6);
          ph_total  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 256)
                                                  : $urandom_range(1, 4);
          ph_repeat = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255)
                                                  : $urandom_range(1, 3);
          ph_threshold = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 40);
          ph_floor = $urandom_range(0, 1) ? 0 : $urandom_range(1, 255);
          ph_masks = {16'($urandom()), 16'($urandom())};
          ph_alpha = $urandom_range(0, 1);
        end
      endcase

      write_reg(CFG_SPAN_X, ph_width);
      write_reg(CFG_SPAN_Y, ph_height);
      write_reg(CFG_SLICE_TOTAL, ph_total);
      write_reg(CFG_DEPTH_REPEAT, ph_repeat);
      write_reg(CFG_LUM_THRESHOLD, ph_threshold);
      write_reg(CFG_RESCALE_FLOOR, ph_floor);
      write_reg(CFG_BIT_MASKS, ph_masks);
      write_reg(CFG_ALPHA_FROM_LUM, ph_alpha);

      case (ph_mode)
        IDLE_SENDER:   begin send_idle_pct = 81; recv_stall_pct = 0;  end
        IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        IDLE_BOTH:     begin send_idle_pct = 35; recv_stall_pct = 35; end
        default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase

      // Back the block up once: hold the result side while requests keep
      // coming at full rate.
      if (ph == 0) hold_off_req = 1'b1;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Mostly full-range samples; some tiny ones sit near the rescale floor.
        rnd_sample = ($urandom_range(0, 3) == 0) ? SAMPLE_W'($urandom_range(0, 31))
                                                 : SAMPLE_W'($urandom());
        send_request(rnd_sample, 1'b0, 1'b0, '0);
      end
      settle();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    settle();

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
